FILE: hw/rtl/hsvpg_pkg.sv
// ----------------------------------------------------------------------------
// hsvpg_pkg
// Types and constants shared by the gradient pixel generator.
// ----------------------------------------------------------------------------
package hsvpg_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;

    localparam logic [7:0]  CHAN_MAX    = 8'd255;
    localparam logic [16:0] FRAC_ONE    = 17'd65280;  // 255 * 256
    localparam logic [11:0] HUE_FULL    = 12'd1536;   // 6 sectors of 256 steps
    localparam logic [10:0] BASE_RED    = 11'd0;
    localparam logic [10:0] BASE_GREEN  = 11'd512;
    localparam logic [10:0] BASE_BLUE   = 11'd1024;
    localparam int          DIV_STEPS   = 16;

    typedef enum logic [2:0] {
        SEC_RY,
        SEC_YG,
        SEC_GC,
        SEC_CB,
        SEC_BM,
        SEC_MR
    } sector_t;

    typedef struct packed {
        logic       busy;
        logic       grey;
        sector_t    sector;
        logic [7:0] frac;
    } hue_status_t;

    // floor(x / 255), exact for x up to 65280
    function automatic logic [8:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return sum[16:8];
    endfunction

endpackage

FILE: hw/rtl/hsvpg_if.sv
// ----------------------------------------------------------------------------
// hsvpg_if
// Channel interfaces: pixel coordinates in, RGB out, register writes.
// ----------------------------------------------------------------------------
interface hsvpg_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] row_value;
    logic [7:0] col_saturation;

    modport source (output valid, output row_value, output col_saturation, input ready);
    modport sink   (input valid, input row_value, input col_saturation, output ready);
endinterface

interface hsvpg_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    output ready);
endinterface

interface hsvpg_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/hsvpg_hue.sv
// ----------------------------------------------------------------------------
// hsvpg_hue
// Reference colour registers and hue unit: sector and fraction found by a
// bit-serial divider after every register write.
// ----------------------------------------------------------------------------
module hsvpg_hue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_valid,
    input  logic [1:0]              wr_index,
    input  logic [7:0]              wr_data,
    output hsvpg_pkg::hue_status_t  status
);
    import hsvpg_pkg::*;

    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic        start_reg;
    logic [4:0]  cnt_reg;
    logic        fin_reg;
    logic        grey_reg;
    sector_t     sector_reg;
    logic [7:0]  frac_reg;

    logic [7:0]  rem_reg;
    logic [15:0] quo_reg;
    logic [7:0]  den_reg;
    logic        neg_reg;
    logic [10:0] base_reg;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  dif;
    logic signed [8:0] num;
    logic [10:0] base_sel;
    logic [7:0]  mag;

    logic [8:0]  trial;
    logic        take;
    logic [7:0]  rem_next;
    logic [15:0] quo_next;

    logic [11:0] qext;
    logic [11:0] hp_raw;
    logic [11:0] hp;

    // max / min with red winning ties, then green
    always_comb
    begin
        mx = red_reg;
        mn = red_reg;
        if (green_reg > mx) mx = green_reg;
        if (blue_reg > mx)  mx = blue_reg;
        if (green_reg < mn) mn = green_reg;
        if (blue_reg < mn)  mn = blue_reg;
        dif = mx - mn;
        if (mx == red_reg)
        begin
            num      = $signed({1'b0, green_reg}) - $signed({1'b0, blue_reg});
            base_sel = BASE_RED;
        end
        else if (mx == green_reg)
        begin
            num      = $signed({1'b0, blue_reg}) - $signed({1'b0, red_reg});
            base_sel = BASE_GREEN;
        end
        else
        begin
            num      = $signed({1'b0, red_reg}) - $signed({1'b0, green_reg});
            base_sel = BASE_BLUE;
        end
        mag = num[8] ? 8'(-num) : num[7:0];
    end

    // restoring division step, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[15]};
        take     = (trial >= {1'b0, den_reg});
        rem_next = take ? 8'(trial - {1'b0, den_reg}) : trial[7:0];
        quo_next = {quo_reg[14:0], take};
    end

    // hue position, wrapped onto the circle
    always_comb
    begin
        qext   = {3'd0, quo_reg[8:0]};
        hp_raw = {1'b0, base_reg} + (neg_reg ? (12'd0 - qext) : qext);
        if (hp_raw[11])
            hp = hp_raw + HUE_FULL;
        else if (hp_raw >= HUE_FULL)
            hp = hp_raw - HUE_FULL;
        else
            hp = hp_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg    <= CHAN_MAX;
            green_reg  <= CHAN_MAX;
            blue_reg   <= CHAN_MAX;
            start_reg  <= 1'b0;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            grey_reg   <= 1'b1;
            sector_reg <= SEC_RY;
            frac_reg   <= '0;
        end
        else
        begin
            if (wr_valid)
            begin
                unique case (wr_index)
                    REG_RED:   red_reg   <= wr_data;
                    REG_GREEN: green_reg <= wr_data;
                    REG_BLUE:  blue_reg  <= wr_data;
                    default:   ;
                endcase
            end
            start_reg <= wr_valid;
            fin_reg   <= 1'b0;
            if (start_reg)
            begin
                cnt_reg  <= 5'(DIV_STEPS);
                grey_reg <= (dif == 8'd0);
            end
            else if (cnt_reg != 5'd0)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                fin_reg <= (cnt_reg == 5'd1);
            end
            if (fin_reg && !start_reg)
            begin
                sector_reg <= sector_t'(hp[10:8]);
                frac_reg   <= hp[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_reg)
        begin
            rem_reg  <= '0;
            quo_reg  <= {mag, 8'd0};
            den_reg  <= dif;
            neg_reg  <= num[8];
            base_reg <= base_sel;
        end
        else if (cnt_reg != 5'd0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_comb
    begin
        status.busy   = start_reg | (cnt_reg != 5'd0) | fin_reg;
        status.grey   = grey_reg;
        status.sector = sector_reg;
        status.frac   = frac_reg;
    end

endmodule

FILE: hw/rtl/hsvpg_pixel_pipe.sv
// ----------------------------------------------------------------------------
// hsvpg_pixel_pipe
// Four-stage pipeline computing p, q, t for one pixel and picking RGB
// by sector, or a grey ramp when the reference is grey.
// ----------------------------------------------------------------------------
module hsvpg_pixel_pipe (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hsvpg_pkg::hue_status_t  hue,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              row,
    input  logic [7:0]              col,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue
);
    import hsvpg_pkg::*;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        adv1, adv2, adv3, adv4;
    logic        in_fire;

    // stage 1
    logic [7:0]  row1_reg, col1_reg;
    logic [15:0] sf1_reg, sg1_reg, pm1_reg;
    // stage 2
    logic [7:0]  row2_reg, col2_reg, p2_reg;
    logic [15:0] qm2_reg, tm2_reg;
    // stage 3
    logic [7:0]  row3_reg, col3_reg, p3_reg;
    logic [23:0] nq3_reg, nt3_reg;
    // stage 4
    logic [7:0]  red_reg, green_reg, blue_reg;

    logic [8:0]  frac_cmp;
    logic [16:0] sg_full;
    logic [7:0]  q4, t4;
    logic [7:0]  red_next, green_next, blue_next;

    assign adv4     = !v4_reg | out_ready;
    assign adv3     = !v3_reg | adv4;
    assign adv2     = !v2_reg | adv3;
    assign adv1     = !v1_reg | adv2;
    assign in_ready = adv1 & !hue.busy;
    assign in_fire  = in_valid & in_ready;

    assign frac_cmp = 9'd256 - {1'b0, hue.frac};
    assign sg_full  = col * frac_cmp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_fire;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_fire)
        begin
            row1_reg <= row;
            col1_reg <= col;
            sf1_reg  <= col * hue.frac;
            sg1_reg  <= sg_full[15:0];
            pm1_reg  <= row * (CHAN_MAX - col);
        end
        if (adv2 && v1_reg)
        begin
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
            qm2_reg  <= 16'(FRAC_ONE - {1'b0, sf1_reg});
            tm2_reg  <= 16'(FRAC_ONE - {1'b0, sg1_reg});
            p2_reg   <= 8'(div255(pm1_reg));
        end
        if (adv3 && v2_reg)
        begin
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
            p3_reg   <= p2_reg;
            nq3_reg  <= row2_reg * qm2_reg;
            nt3_reg  <= row2_reg * tm2_reg;
        end
        if (adv4 && v3_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // select by sector; a grey reference gives a ramp on the column
    always_comb
    begin
        q4 = 8'(div255(nq3_reg[23:8]));
        t4 = 8'(div255(nt3_reg[23:8]));
        case (hue.sector)
            SEC_RY:  begin red_next = row3_reg; green_next = t4;       blue_next = p3_reg;   end
            SEC_YG:  begin red_next = q4;       green_next = row3_reg; blue_next = p3_reg;   end
            SEC_GC:  begin red_next = p3_reg;   green_next = row3_reg; blue_next = t4;       end
            SEC_CB:  begin red_next = p3_reg;   green_next = q4;       blue_next = row3_reg; end
            SEC_BM:  begin red_next = t4;       green_next = p3_reg;   blue_next = row3_reg; end
            default: begin red_next = row3_reg; green_next = p3_reg;   blue_next = q4;       end
        endcase
        if (hue.grey)
        begin
            red_next   = CHAN_MAX - col3_reg;
            green_next = CHAN_MAX - col3_reg;
            blue_next  = CHAN_MAX - col3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

FILE: hw/rtl/hsv_picker_gradient_pixel.sv
// ----------------------------------------------------------------------------
// hsv_picker_gradient_pixel
// Colour-picker gradient pixel generator, HSV to RGB in fixed point.
// ----------------------------------------------------------------------------
// usage
//   cfg   : register writes; index 0/1/2 = reference red/green/blue, the
//           reference colour sets the hue (sector and 8-bit fraction)
//   pixel : one transaction per pixel, row_value = V, col_saturation = S
//   color : one transaction per pixel with its RGB, in input order
// throughput
//   one pixel per clock sustained while color.ready is high and the hue
//   unit is idle; a 4-entry pipeline, the last stage is the output register
// configuration
//   each register write reruns the hue divider, one quotient bit a cycle;
//   pixel.ready stays low until the new hue is loaded, cfg.ready is
//   always high; write only while no pixel is in flight
// reset
//   reference colour returns to white (grey ramp), pipeline empties
// stall
//   when color.ready is low the output holds, and the stages behind it
//   keep filling until the pipeline is full, then pixel.ready drops
// ----------------------------------------------------------------------------
module hsv_picker_gradient_pixel (
    input  logic        clk,
    input  logic        rst_n,
    hsvpg_cfg_if.sink   cfg,
    hsvpg_pix_if.sink   pixel,
    hsvpg_rgb_if.source color
);
    import hsvpg_pkg::*;

    hue_status_t hue;

    assign cfg.ready = 1'b1;

    hsvpg_hue u_hue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .status   (hue)
    );

    hsvpg_pixel_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .hue       (hue),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .row       (pixel.row_value),
        .col       (pixel.col_saturation),
        .out_valid (color.valid),
        .out_ready (color.ready),
        .red       (color.out_red),
        .green     (color.out_green),
        .blue      (color.out_blue)
    );

endmodule

FILE: hw/rtl/hsvpg_checker.sv
// ----------------------------------------------------------------------------
// hsvpg_checker
// Port-level checks on the gradient pixel generator, bound to the top.
// ----------------------------------------------------------------------------
module hsvpg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       pix_ready,
    input logic       rgb_valid,
    input logic       rgb_ready,
    input logic [7:0] rgb_red,
    input logic [7:0] rgb_green,
    input logic [7:0] rgb_blue
);

    // hue unit blocks pixels right after a register write
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !pix_ready)
        else $error("pixel accepted right after register write");

    // and is still busy at the end of the divide
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> ##16 !pix_ready)
        else $error("pixel accepted before hue divide finished");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> rgb_valid)
        else $error("output dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=>
            $stable(rgb_red) && $stable(rgb_green) && $stable(rgb_blue))
        else $error("output changed while stalled");

endmodule

bind hsv_picker_gradient_pixel hsvpg_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .pix_ready (pixel.ready),
    .rgb_valid (color.valid),
    .rgb_ready (color.ready),
    .rgb_red   (color.out_red),
    .rgb_green (color.out_green),
    .rgb_blue  (color.out_blue)
);
